// ===== sv/sfp_pkg.sv =====
// Shared constants, types and helpers for the spring-follow particle step block.
package sfp_pkg;

    localparam int Q_FRAC = 16;
    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    localparam int SPRING_W = 26;

    localparam int DEF_SCREEN_WIDTH = 1280;
    localparam int DEF_SCREEN_HEIGHT = 720;
    localparam int DEF_EDGE_MARGIN = 50;

    localparam logic [31:0] RST_REST_LENGTH = 32'd2949120;
    localparam logic [31:0] RST_STIFFNESS = 32'd13107;
    localparam logic [31:0] RST_INVERSE_MASS = 32'd16384;
    localparam logic [31:0] RST_FRICTION_SIZE = 32'd2457600;
    localparam logic signed [31:0] RST_POS_XY = 32'sd19660800;

    localparam logic [SPRING_W-1:0] SPRING_MAX = SPRING_W'(1000 * 65536);

    typedef enum logic [1:0] {
        CFG_REST_LENGTH   = 2'd0,
        CFG_STIFFNESS     = 2'd1,
        CFG_INVERSE_MASS  = 2'd2,
        CFG_FRICTION_SIZE = 2'd3
    } cfg_index_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

// ===== sv/sfp_mul.sv =====
// Bit-serial unsigned 32x32 multiplier, one multiplier bit per cycle.
module sfp_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sfp_pkg::WORD_W-1:0]  a,
    input  logic [sfp_pkg::WORD_W-1:0]  b,
    output logic                        busy,
    output logic [sfp_pkg::PROD_W-1:0]  p
);
    import sfp_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [WORD_W:0]   sum;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        prod_next = prod_reg;
        sum = {1'b0, prod_reg[PROD_W-1:WORD_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            prod_next = {{WORD_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_next = {sum, prod_reg[WORD_W-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign busy = busy_reg;
    assign p    = prod_reg;

endmodule

// ===== sv/sfp_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module sfp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sfp_pkg::PROD_W-1:0]  dividend,
    input  logic [sfp_pkg::WORD_W-1:0]  divisor,
    output logic                        busy,
    output logic [sfp_pkg::PROD_W-1:0]  quo
);
    import sfp_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] dv_reg, dv_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [WORD_W:0]   sh;
    logic              ge;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dv_next   = dv_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        sh = {rem_reg, quo_reg[PROD_W-1]};
        ge = (sh >= {1'b0, dv_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dv_next   = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? WORD_W'(sh - {1'b0, dv_reg}) : sh[WORD_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PROD_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/sfp_sqrt.sv =====
// Digit-by-digit integer square root of a 64-bit word, two radicand bits per cycle.
module sfp_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sfp_pkg::PROD_W-1:0]  n,
    output logic                        busy,
    output logic [sfp_pkg::WORD_W-1:0]  root
);
    import sfp_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);
    localparam int REM_W = WORD_W + 2;

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] n_reg, n_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  sh, trial;
    logic              ge;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        sh    = {rem_reg, n_reg[PROD_W-1:PROD_W-2]};
        trial = {2'b00, root_reg, 2'b01};
        ge    = (sh >= trial);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = n;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? REM_W'(sh - trial) : sh[REM_W-1:0];
            root_next = {root_reg[WORD_W-2:0], ge};
            n_next    = {n_reg[PROD_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== sv/spring_follow_particle_step_top.sv =====
// Top level of the spring-follow particle step: sequencer, state and arithmetic units.
//
// One input word is one frame: the particle is pulled toward the target by a clamped
// spring, slowed by a fixed friction against its velocity, integrated once and clamped
// to the screen margins; one output word carries the new position and a moving flag.
// The arithmetic runs on one bit-serial multiplier, one restoring divider and one
// square-root unit, used in sequence: two vector lengths of three squares each, the
// spring product, and per axis two products with a division each plus the mass
// product. A new frame is taken once the sequencer is back in idle;
// the finished result sits in the output register until it is taken.
module spring_follow_particle_step_top #(
    parameter int SCREEN_WIDTH  = sfp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = sfp_pkg::DEF_SCREEN_HEIGHT,
    parameter int EDGE_MARGIN   = sfp_pkg::DEF_EDGE_MARGIN
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  sfp_pkg::cfg_index_t cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  target_x,
    input  logic signed [31:0]  target_y,
    input  logic signed [31:0]  target_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic                moving
);
    import sfp_pkg::*;

    // margins in Q16.16
    localparam logic signed [31:0] X_LO = 32'(EDGE_MARGIN * 65536);
    localparam logic signed [31:0] X_HI = 32'((SCREEN_WIDTH - EDGE_MARGIN) * 65536);
    localparam logic signed [31:0] Y_LO = 32'(EDGE_MARGIN * 65536);
    localparam logic signed [31:0] Y_HI = 32'((SCREEN_HEIGHT - EDGE_MARGIN) * 65536);

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_SQ   = 18'h00002,
        S_SQW  = 18'h00004,
        S_RT   = 18'h00008,
        S_RTW  = 18'h00010,
        S_SP   = 18'h00020,
        S_SPW  = 18'h00040,
        S_M1   = 18'h00080,
        S_M1W  = 18'h00100,
        S_D1   = 18'h00200,
        S_D1W  = 18'h00400,
        S_M2   = 18'h00800,
        S_M2W  = 18'h01000,
        S_D2   = 18'h02000,
        S_D2W  = 18'h04000,
        S_M3   = 18'h08000,
        S_M3W  = 18'h10000,
        S_OUT  = 18'h20000
    } state_t;

    // configuration
    logic [31:0] rest_reg, stiff_reg, imass_reg, fric_reg;

    // sequencer
    state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic pass_reg, pass_next;          // 0: target delta, 1: velocity

    // frame state and working registers
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_next [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] d_next [3];
    logic signed [31:0] prev_reg [2];
    logic signed [31:0] prev_next [2];
    logic [PROD_W-1:0]   sum_reg, sum_next;
    logic [WORD_W-1:0]   len_reg, len_next, vl_reg, vl_next;
    logic [SPRING_W-1:0] f_reg, f_next, s1_reg, s1_next;
    logic signed [31:0]  force_reg, force_next;
    logic moving_reg, moving_next;

    // output word
    logic out_valid_reg, out_valid_next;
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic mv_reg, mv_next;

    // arithmetic units
    logic              mul_start, mul_busy, div_start, div_busy, sq_start, sq_busy;
    logic [WORD_W-1:0] mul_a, mul_b, div_dv, sq_root;
    logic [PROD_W-1:0] mul_p, div_q;

    sfp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .p     (mul_p)
    );

    sfp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_p),
        .divisor  (div_dv),
        .busy     (div_busy),
        .quo      (div_q)
    );

    sfp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .n     (sum_reg),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    // helpers
    logic [31:0]        diff;
    logic [47:0]        spring_raw, am;
    logic [31:0]        s2;
    logic signed [35:0] sd, sv, tmp;
    logic signed [31:0] acc, vnew, pnew;
    logic [31:0]        accm;
    logic               in_acc;

    assign in_acc    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign diff      = (len_reg > rest_reg) ? len_reg - rest_reg : 32'd0;
    assign mul_start = (state_reg == S_SQ) || (state_reg == S_SP) || (state_reg == S_M1)
                    || (state_reg == S_M2) || (state_reg == S_M3);
    assign div_start = (state_reg == S_D1) || (state_reg == S_D2);
    assign sq_start  = (state_reg == S_RT);
    assign div_dv    = (state_reg == S_D1) ? len_reg : vl_reg;

    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = pass_reg ? mag32(vel_reg[axis_reg]) : mag32(d_reg[axis_reg]);
                mul_b = mul_a;
            end
            S_SP:
            begin
                mul_a = stiff_reg;
                mul_b = diff;
            end
            S_M1:
            begin
                mul_a = 32'(f_reg);
                mul_b = mag32(d_reg[axis_reg]);
            end
            S_M2:
            begin
                mul_a = fric_reg;
                mul_b = mag32(vel_reg[axis_reg]);
            end
            default:
            begin
                mul_a = mag32(force_reg);
                mul_b = imass_reg;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg  <= RST_REST_LENGTH;
            stiff_reg <= RST_STIFFNESS;
            imass_reg <= RST_INVERSE_MASS;
            fric_reg  <= RST_FRICTION_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REST_LENGTH:   rest_reg  <= cfg_data;
                CFG_STIFFNESS:     stiff_reg <= cfg_data;
                CFG_INVERSE_MASS:  imass_reg <= cfg_data;
                CFG_FRICTION_SIZE: fric_reg  <= cfg_data;
                default:           rest_reg  <= rest_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        pass_next      = pass_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        d_next         = d_reg;
        prev_next      = prev_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        vl_next        = vl_reg;
        f_next         = f_reg;
        s1_next        = s1_reg;
        force_next     = force_reg;
        moving_next    = moving_reg;
        out_valid_next = out_valid_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        mv_next        = mv_reg;

        spring_raw = mul_p[63:16];
        s2   = (vl_reg == 32'd0) ? 32'd0 : div_q[31:0];
        sd   = d_reg[axis_reg][31] ? -36'(s1_reg) : 36'(s1_reg);
        sv   = vel_reg[axis_reg][31] ? -36'(s2) : 36'(s2);
        am   = mul_p[63:16];
        if (force_reg[31])
            accm = (am > 48'h80000000) ? 32'h80000000 : am[31:0];
        else
            accm = (am > 48'h7fffffff) ? 32'h7fffffff : am[31:0];
        acc  = force_reg[31] ? 32'(-accm) : 32'(accm);
        tmp  = 36'(vel_reg[axis_reg]) + 36'(acc);
        vnew = sat32(tmp);
        tmp  = 36'(pos_reg[axis_reg]) + 36'(vnew);
        pnew = sat32(tmp);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    moving_next  = (target_x != prev_reg[0]) || (target_y != prev_reg[1]);
                    prev_next[0] = target_x;
                    prev_next[1] = target_y;
                    d_next[0]    = sat32(36'(target_x) - 36'(pos_reg[0]));
                    d_next[1]    = sat32(36'(target_y) - 36'(pos_reg[1]));
                    d_next[2]    = sat32(36'(target_z) - 36'(pos_reg[2]));
                    sum_next     = '0;
                    axis_next    = 2'd0;
                    pass_next    = 1'b0;
                    state_next   = S_SQ;
                end
            end
            S_SQ:  state_next = S_SQW;
            S_SQW:
            begin
                if (!mul_busy)
                begin
                    sum_next = sum_reg + mul_p;
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        state_next = S_RT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_SQ;
                    end
                end
            end
            S_RT:  state_next = S_RTW;
            S_RTW:
            begin
                if (!sq_busy)
                begin
                    if (!pass_reg)
                    begin
                        len_next   = sq_root;
                        state_next = S_SP;
                    end
                    else
                    begin
                        vl_next    = sq_root;
                        state_next = S_M1;
                    end
                end
            end
            S_SP:  state_next = S_SPW;
            S_SPW:
            begin
                if (!mul_busy)
                begin
                    // spring pull clamped to 1000.0
                    f_next = (spring_raw > 48'(SPRING_MAX)) ? SPRING_MAX
                                                            : spring_raw[SPRING_W-1:0];
                    pass_next  = 1'b1;
                    sum_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_M1:  state_next = S_M1W;
            S_M1W: if (!mul_busy) state_next = S_D1;
            S_D1:  state_next = S_D1W;
            S_D1W:
            begin
                if (!div_busy)
                begin
                    // zero length: no pull direction
                    s1_next    = (len_reg == 32'd0) ? '0 : div_q[SPRING_W-1:0];
                    state_next = S_M2;
                end
            end
            S_M2:  state_next = S_M2W;
            S_M2W: if (!mul_busy) state_next = S_D2;
            S_D2:  state_next = S_D2W;
            S_D2W:
            begin
                if (!div_busy)
                begin
                    force_next = sat32(sd - sv);
                    state_next = S_M3;
                end
            end
            S_M3:  state_next = S_M3W;
            S_M3W:
            begin
                if (!mul_busy)
                begin
                    vel_next[axis_reg] = vnew;
                    pos_next[axis_reg] = pnew;
                    if (axis_reg == 2'd0)
                        pos_next[0] = (pnew < X_LO) ? X_LO : ((pnew > X_HI) ? X_HI : pnew);
                    else if (axis_reg == 2'd1)
                        pos_next[1] = (pnew < Y_LO) ? Y_LO : ((pnew > Y_HI) ? Y_HI : pnew);
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_M1;
                    end
                end
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = pos_reg[0];
                    oy_next        = pos_reg[1];
                    oz_next        = pos_reg[2];
                    mv_next        = moving_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 2'd0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg[0]    <= RST_POS_XY;
            pos_reg[1]    <= RST_POS_XY;
            pos_reg[2]    <= '0;
            vel_reg[0]    <= '0;
            vel_reg[1]    <= '0;
            vel_reg[2]    <= '0;
            prev_reg[0]   <= '0;
            prev_reg[1]   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        sum_reg    <= sum_next;
        len_reg    <= len_next;
        vl_reg     <= vl_next;
        f_reg      <= f_next;
        s1_reg     <= s1_next;
        force_reg  <= force_next;
        moving_reg <= moving_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        mv_reg     <= mv_next;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign moving    = mv_reg;

    // a taken frame keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input taken again right after a frame was accepted");

    // multiplier and divider share the product word, never both running
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    a_x_margin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_x >= X_LO) && (out_x <= X_HI))
        else $error("out_x outside the screen margins");

    a_y_margin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_y >= Y_LO) && (out_y <= Y_HI))
        else $error("out_y outside the screen margins");

endmodule

// ===== test/testbench.sv =====
// Testbench for the spring-follow particle step: directed and random frames checked against a predictor.
module testbench;
    import sfp_pkg::*;

    localparam longint ONE = 65536;
    localparam int CYCLE_LIMIT = 12000000;
    localparam int LONG_HOLD = 4000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               mv;
    } frame_t;

    // Scoreboard: carries its own copy of particle state and registers, predicts
    // the next frame on each accepted target word, checks result words in order.
    class particle_scoreboard;
        bit [31:0] rest_len, stiff, inv_mass, fric;
        longint pos[3];
        longint vel[3];
        longint prev_t[2];
        frame_t pending[$];
        int mismatches;
        int checked;

        function new();
            rest_len = RST_REST_LENGTH;
            stiff    = RST_STIFFNESS;
            inv_mass = RST_INVERSE_MASS;
            fric     = RST_FRICTION_SIZE;
            pos[0] = 300 * ONE;
            pos[1] = 300 * ONE;
            pos[2] = 0;
            foreach (vel[i]) vel[i] = 0;
            prev_t[0] = 0;
            prev_t[1] = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(cfg_index_t idx, bit [31:0] v);
            case (idx)
                CFG_REST_LENGTH:   rest_len = v;
                CFG_STIFFNESS:     stiff = v;
                CFG_INVERSE_MASS:  inv_mass = v;
                CFG_FRICTION_SIZE: fric = v;
                default: ;
            endcase
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint unsigned vec_len(longint v[3]);
            longint unsigned s;
            s = 0;
            for (int i = 0; i < 3; i++) s += mag(v[i]) * mag(v[i]);
            return isqrt(s);
        endfunction

        // sign(v) * scale*|v| / len, zero for a zero length
        function longint along(longint unsigned scale, longint v, longint unsigned len);
            longint unsigned q;
            if (len == 0) return 0;
            q = (scale * mag(v)) / len;
            return v < 0 ? -longint'(q) : longint'(q);
        endfunction

        function void note_input(logic signed [31:0] tx, logic signed [31:0] ty,
                                 logic signed [31:0] tz);
            longint t[3];
            longint d[3];
            longint unsigned len, vl, diff, f, am;
            longint force_v, acc;
            frame_t e;
            t[0] = tx;
            t[1] = ty;
            t[2] = tz;
            e.mv = (t[0] != prev_t[0]) || (t[1] != prev_t[1]);
            prev_t[0] = t[0];
            prev_t[1] = t[1];
            for (int i = 0; i < 3; i++) d[i] = sat(t[i] - pos[i]);
            len = vec_len(d);
            diff = len > rest_len ? len - rest_len : 0;
            f = (longint'(stiff) * diff) >> 16;   // full 64-bit product, as in the design
            if (f > 1000 * ONE) f = 1000 * ONE;
            vl = vec_len(vel);
            for (int i = 0; i < 3; i++) begin
                force_v = sat(along(f, d[i], len) - along(fric, vel[i], vl));
                am = (mag(force_v) * longint'(inv_mass)) >> 16;
                acc = sat(force_v < 0 ? -longint'(am) : longint'(am));
                vel[i] = sat(vel[i] + acc);
                pos[i] = sat(pos[i] + vel[i]);
            end
            if (pos[0] < DEF_EDGE_MARGIN * ONE) pos[0] = DEF_EDGE_MARGIN * ONE;
            if (pos[0] > (DEF_SCREEN_WIDTH - DEF_EDGE_MARGIN) * ONE)
                pos[0] = (DEF_SCREEN_WIDTH - DEF_EDGE_MARGIN) * ONE;
            if (pos[1] < DEF_EDGE_MARGIN * ONE) pos[1] = DEF_EDGE_MARGIN * ONE;
            if (pos[1] > (DEF_SCREEN_HEIGHT - DEF_EDGE_MARGIN) * ONE)
                pos[1] = (DEF_SCREEN_HEIGHT - DEF_EDGE_MARGIN) * ONE;
            e.x = pos[0][31:0];
            e.y = pos[1][31:0];
            e.z = pos[2][31:0];
            pending.push_back(e);
        endfunction

        function void check_result(frame_t got);
            frame_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word x=%0d y=%0d z=%0d moving=%0b",
                             got.x, got.y, got.z, got.mv);
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.mv !== e.mv) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: expected x=%0d y=%0d z=%0d mv=%0b, got x=%0d y=%0d z=%0d mv=%0b",
                             checked, e.x, e.y, e.z, e.mv, got.x, got.y, got.z, got.mv);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    cfg_index_t         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] target_x, target_y, target_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x, out_y, out_z;
    logic               moving;

    particle_scoreboard sb;
    int  cycles;
    int  words_sent;
    int  cfg_writes;
    bit  hold_done;

    spring_follow_particle_step_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .moving(moving)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog; the slowest run is about 1850 frames plus one long hold.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Idle draw: whole bursts with no gaps, otherwise a random idle gap.
    function automatic int draw_gap(int n);
        if ((n / 48) % 3 == 0) return 0;
        return $urandom_range(0, 5);
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
        cfg_writes++;
    endtask

    // One target word: hold valid and payload until accepted, note it at the accepting edge.
    task automatic send_word(logic signed [31:0] tx, logic signed [31:0] ty,
                             logic signed [31:0] tz);
        int gap;
        gap = draw_gap(words_sent);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        target_x <= tx;
        target_y <= ty;
        target_z <= tz;
        do @(posedge clk); while (!in_ready);
        sb.note_input(tx, ty, tz);
        words_sent++;
    endtask

    // Random target: mostly on-screen with small z, some full-range, some repeats
    // of the last x/y (no motion), some close to the particle (inside rest length).
    task automatic send_random();
        int kind;
        logic signed [31:0] tx, ty, tz;
        kind = $urandom_range(0, 9);
        tx = 32'($urandom_range(0, 1400) * ONE + $urandom_range(0, 65535));
        ty = 32'($urandom_range(0, 800) * ONE + $urandom_range(0, 65535));
        tz = $signed($urandom_range(0, 400 * 65536)) - 200 * 65536;
        if (kind <= 1) begin
            tx = $urandom;
            ty = $urandom;
            tz = $urandom;
        end
        else if (kind == 2) begin
            tx = sb.prev_t[0][31:0];
            ty = sb.prev_t[1][31:0];
        end
        else if (kind == 3) begin
            tx = sb.pos[0][31:0] + $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
            ty = sb.pos[1][31:0] + $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
            tz = sb.pos[2][31:0];
        end
        send_word(tx, ty, tz);
    endtask

    // Registers change only when every frame has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Receiver: random stalls, one long hold so the block backs up into its input.
    initial
    begin
        int stall;
        frame_t got;
        out_ready <= 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = draw_gap(sb.checked + 7);
            if (!hold_done && sb.checked == 300) begin
                stall = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.x = out_x;
            got.y = out_y;
            got.z = out_z;
            got.mv = moving;
            sb.check_result(got);
        end
    end

    initial
    begin
        logic [31:0] r;
        sb = new();
        cycles = 0;
        words_sent = 0;
        cfg_writes = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_REST_LENGTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        target_x <= '0;
        target_y <= '0;
        target_z <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: target on the particle while at rest, inside rest length,
        // repeated x/y, field extremes, far off screen.
        send_word(32'(300 * ONE), 32'(300 * ONE), 0);
        send_word(32'(310 * ONE), 32'(300 * ONE), 0);
        send_word(32'(310 * ONE), 32'(300 * ONE), 32'(5 * ONE));
        send_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_word(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_word(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_word(0, 0, 0);
        send_word(-1, -1, -1);
        send_word(32'(2000 * ONE), 32'(-500 * ONE), 32'(1000 * ONE));
        send_word(32'(640 * ONE), 32'(360 * ONE), 0);
        send_word(32'(640 * ONE), 32'(360 * ONE), 0);
        send_word(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555);
        repeat (390) send_random();
        drain();

        // Everything off: no pull, no friction, no mass response.
        write_reg(CFG_REST_LENGTH, 32'h0);
        write_reg(CFG_STIFFNESS, 32'h0);
        write_reg(CFG_INVERSE_MASS, 32'h0);
        write_reg(CFG_FRICTION_SIZE, 32'h0);
        repeat (150) send_random();
        drain();

        // All-ones: spring pull clamped, forces saturate.
        write_reg(CFG_STIFFNESS, 32'hffffffff);
        write_reg(CFG_INVERSE_MASS, 32'hffffffff);
        write_reg(CFG_FRICTION_SIZE, 32'hffffffff);
        repeat (100) send_random();
        drain();
        write_reg(CFG_REST_LENGTH, 32'hffffffff);
        write_reg(CFG_FRICTION_SIZE, 32'h0);
        repeat (50) send_random();
        drain();

        // Random settings, mixing plausible and full-range values.
        for (int p = 0; p < 4; p++) begin
            r = (p % 2) ? $urandom : $urandom_range(0, 100 * 65536);
            write_reg(CFG_REST_LENGTH, r);
            r = (p % 2) ? $urandom : $urandom_range(0, 2 * 65536);
            write_reg(CFG_STIFFNESS, r);
            r = (p == 3) ? $urandom : $urandom_range(0, 65536);
            write_reg(CFG_INVERSE_MASS, r);
            r = (p == 1) ? $urandom : $urandom_range(0, 80 * 65536);
            write_reg(CFG_FRICTION_SIZE, r);
            repeat (285) send_random();
            drain();
        end

        repeat (2000) @(posedge clk);
        $display("covered %0d frames over %0d register writes, %0d results checked",
                 words_sent, cfg_writes, sb.checked);
        $display("settings: reset values, all zero, all ones, four random sets");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else begin
            $display("%0d mismatches, %0d frames never returned",
                     sb.mismatches, sb.pending.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/sfp_pkg.sv
sv/sfp_mul.sv
sv/sfp_div.sv
sv/sfp_sqrt.sv
sv/spring_follow_particle_step_top.sv
test/testbench.sv
